[rtl/text_cursor_glyph_placer_core_assert.svh]
// assertion macros shared by the rtl
`ifndef TEXT_CURSOR_GLYPH_PLACER_CORE_ASSERT_SVH
`define TEXT_CURSOR_GLYPH_PLACER_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define TCGP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define TCGP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TCGP_ASSERT_NOW(label, ante, cons)
`define TCGP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/tcgp_pkg.sv]
package tcgp_pkg;

	// character codes
	localparam logic [7:0] CODE_TAB     = 8'd9;
	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] GLYPH_FIRST  = 8'd32;
	localparam logic [7:0] GLYPH_LAST   = 8'd126;
	localparam logic [7:0] CODE_SUB0    = 8'd126;
	localparam logic [7:0] CODE_SUB1    = 8'd128;
	localparam logic [7:0] CODE_SUB2    = 8'd129;
	localparam logic [7:0] CODE_SUB3    = 8'd130;

	localparam logic [8:0] SUBSET_GLYPHS = 9'd96;
	localparam logic [2:0] TAB_STOP      = 3'd4;

	// opcodes
	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_GOTO = 1'b1;

	// register indexes
	localparam logic [1:0] REG_CELL_W   = 2'd0;
	localparam logic [1:0] REG_CELL_H   = 2'd1;
	localparam logic [1:0] REG_SUBSETS  = 2'd2;
	localparam logic [1:0] REG_WIDE     = 2'd3;

	// divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

[rtl/text_cursor_glyph_placer_core.sv]
// states from accept to result valid: goto, subset, newline and unprintable codes
// pass ST_EXEC and ST_DONE, a drawn glyph ST_EXEC, ST_MULT and ST_DONE, a tab
// ST_EXEC, ST_DIV and ST_DONE (ST_DONE straight away if the cell width is zero)
// one item is processed at a time; a tab waits on the 16-step serial divider
// a finished result waits in the output register while the next item is accepted
// reset: cursor, margin and subset clear to 0, registers return to 8, 8, 1, 0
module text_cursor_glyph_placer_core (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [7:0]  char_code,
	input  logic        embed,
	input  logic [15:0] goto_x,
	input  logic [15:0] goto_y,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        draw_valid,
	output logic [15:0] draw_x,
	output logic [15:0] draw_y,
	output logic [23:0] glyph_offset,
	output logic [15:0] cursor_x,
	output logic [15:0] cursor_y,
	output logic [1:0]  subset_now,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tcgp_pkg::*;

`include "text_cursor_glyph_placer_core_assert.svh"

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_MULT = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [7:0] cell_w_q;
	logic [7:0] cell_h_q;
	logic [2:0] subsets_q;
	logic       wide_q;

	// layout state
	logic [15:0] pos_x_q;
	logic [15:0] pos_y_q;
	logic [15:0] margin_q;
	logic [1:0]  subset_q;

	// captured transaction
	logic        op_q;
	logic [7:0]  code_q;
	logic        embed_q;
	logic [15:0] gx_q;
	logic [15:0] gy_q;

	// work registers
	logic        drw_q;
	logic [15:0] dx_q;
	logic [15:0] dy_q;
	logic [23:0] goff_q;
	logic [15:0] cell_q;
	logic [8:0]  idx_q;
	logic        neg_q;

	// result register
	logic        out_valid_q;
	logic        res_draw_q;
	logic [15:0] res_dx_q;
	logic [15:0] res_dy_q;
	logic [23:0] res_goff_q;
	logic [15:0] res_cx_q;
	logic [15:0] res_cy_q;
	logic [1:0]  res_sub_q;

	// apb write strobe
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_w_q  <= 8'd8;
			cell_h_q  <= 8'd8;
			subsets_q <= 3'd1;
			wide_q    <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_CELL_W:  cell_w_q  <= pwdata[7:0];
				REG_CELL_H:  cell_h_q  <= pwdata[7:0];
				REG_SUBSETS: subsets_q <= pwdata[2:0];
				REG_WIDE:    wide_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_CELL_W:  prdata = {24'd0, cell_w_q};
			REG_CELL_H:  prdata = {24'd0, cell_h_q};
			REG_SUBSETS: prdata = {29'd0, subsets_q};
			REG_WIDE:    prdata = {31'd0, wide_q};
			default:     prdata = '0;
		endcase
	end

	// code decode for the captured byte
	logic       is_sel;
	logic [1:0] sel_num;
	logic       is_tab;
	logic       is_nl;
	logic       is_print;

	always_comb begin
		is_sel  = 1'b1;
		sel_num = 2'd0;
		case (code_q)
			CODE_SUB0: sel_num = 2'd0;
			CODE_SUB1: sel_num = 2'd1;
			CODE_SUB2: sel_num = 2'd2;
			CODE_SUB3: sel_num = 2'd3;
			default:   is_sel = 1'b0;
		endcase
	end

	assign is_tab   = embed_q && (code_q == CODE_TAB);
	assign is_nl    = embed_q && (code_q == CODE_NEWLINE);
	assign is_print = (code_q >= GLYPH_FIRST) && (code_q <= GLYPH_LAST);

	// signed column distance from the margin, folded to a magnitude for the divider
	logic [16:0] diff;
	logic [16:0] mag;
	assign diff = {pos_x_q[15], pos_x_q} - {margin_q[15], margin_q};
	assign mag  = diff[16] ? (17'd0 - diff) : diff;

	// divider for the tab advance
	logic              div_start;
	logic [15:0]       div_quo;
	div_status_t       div_st;

	assign div_start = (state_q == ST_EXEC) && (op_q == OP_CHAR) && !is_sel && is_tab
		&& (cell_w_q != 8'd0);

	tcgp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag[15:0]),
		.divisor  (cell_w_q),
		.quotient (div_quo),
		.status   (div_st)
	);

	// tab advance: stop distance in cells times cell width
	// a negative column gives remainder -r, so the distance becomes 4 + r
	logic [2:0]  tab_cells;
	logic [10:0] tab_adv;
	assign tab_cells = neg_q ? (TAB_STOP + {1'b0, div_quo[1:0]})
		: (TAB_STOP - {1'b0, div_quo[1:0]});
	assign tab_adv = tab_cells * cell_w_q;

	// glyph index within the font
	logic [8:0] glyph_idx;
	assign glyph_idx = ({7'd0, subset_q} * SUBSET_GLYPHS) + {1'b0, code_q - GLYPH_FIRST};

	logic [24:0] off_full;
	assign off_full = idx_q * cell_q;

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	assign in_ready = (state_q == ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			margin_q    <= '0;
			subset_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					if (op_q == OP_GOTO) begin
						margin_q <= gx_q;
						pos_x_q  <= gx_q;
						pos_y_q  <= gy_q;
					end else if (is_sel) begin
						if ({1'b0, sel_num} < subsets_q) begin
							subset_q <= sel_num;
						end
					end else if (is_tab) begin
						// zero cell width leaves the cursor where it is
						if (cell_w_q != 8'd0) begin
							state_q <= ST_DIV;
						end
					end else if (is_nl) begin
						pos_y_q <= pos_y_q + {8'd0, cell_h_q};
						pos_x_q <= margin_q;
					end else begin
						pos_x_q <= pos_x_q + {8'd0, cell_w_q};
						if (is_print) begin
							state_q <= ST_MULT;
						end
					end
				end
				ST_DIV: begin
					if (div_st.done) begin
						pos_x_q <= pos_x_q + {5'd0, tab_adv};
						state_q <= ST_DONE;
					end
				end
				ST_MULT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q    <= opcode;
			code_q  <= char_code;
			embed_q <= embed;
			gx_q    <= goto_x;
			gy_q    <= goto_y;
		end
		if (state_q == ST_EXEC) begin
			drw_q  <= 1'b0;
			dx_q   <= '0;
			dy_q   <= '0;
			goff_q <= '0;
			neg_q  <= diff[16];
			cell_q <= cell_w_q * cell_h_q;
			idx_q  <= glyph_idx;
			if ((op_q == OP_CHAR) && !is_sel && !is_tab && !is_nl && is_print) begin
				drw_q <= 1'b1;
				dx_q  <= pos_x_q;
				dy_q  <= pos_y_q;
			end
		end
		if (state_q == ST_MULT) begin
			goff_q <= wide_q ? {off_full[22:0], 1'b0} : off_full[23:0];
		end
		if ((state_q == ST_DONE) && out_free) begin
			res_draw_q <= drw_q;
			res_dx_q   <= dx_q;
			res_dy_q   <= dy_q;
			res_goff_q <= goff_q;
			res_cx_q   <= pos_x_q;
			res_cy_q   <= pos_y_q;
			res_sub_q  <= subset_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign draw_valid   = res_draw_q;
	assign draw_x       = res_dx_q;
	assign draw_y       = res_dy_q;
	assign glyph_offset = res_goff_q;
	assign cursor_x     = res_cx_q;
	assign cursor_y     = res_cy_q;
	assign subset_now   = res_sub_q;

	// checks
	`TCGP_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_q == ST_EXEC)
	`TCGP_ASSERT_NOW(a_div_done_in_div, div_st.done, state_q == ST_DIV)
	`TCGP_ASSERT_NOW(a_nodraw_zero, out_valid && !draw_valid,
		draw_x == 16'd0 && draw_y == 16'd0 && glyph_offset == 24'd0)

endmodule

[rtl/tcgp_div.sv]
module tcgp_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [15:0]               dividend,
	input  logic [7:0]                divisor,
	output logic [15:0]               quotient,
	output tcgp_pkg::div_status_t     status
);
	import tcgp_pkg::*;

	// restoring divider, one quotient bit per cycle
	logic [7:0]  rem_q;
	logic [15:0] quo_q;
	logic [7:0]  dvs_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [9:0]  trial;

	assign trial = {1'b0, rem_q, quo_q[15]} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[9]) begin
				rem_q <= trial[7:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[6:0], quo_q[15]};
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule
